### rtl/grid_path_validator_macros.svh
// ----------------------------------------------------------------------------
// Grid path validator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRID_PATH_VALIDATOR_MACROS_SVH
`define GRID_PATH_VALIDATOR_MACROS_SVH

// same-cycle implication
`define GPV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GPV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gpv_pkg.sv
// ----------------------------------------------------------------------------
// Grid path validator package
// Request codes, queue entry, configuration and result types, cost constants.
// ----------------------------------------------------------------------------
package gpv_pkg;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_CELL   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [2:0] CFG_GRID_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_EIGHT_WAY    = 3'd2;
  localparam logic [2:0] CFG_ALLOW_CORNER = 3'd3;
  localparam logic [2:0] CFG_START_X      = 3'd4;
  localparam logic [2:0] CFG_START_Y      = 3'd5;
  localparam logic [2:0] CFG_GOAL_X       = 3'd6;
  localparam logic [2:0] CFG_GOAL_Y       = 3'd7;

  localparam logic [31:0] COST_STRAIGHT = 32'd65536;
  localparam logic [31:0] COST_DIAGONAL = 32'd92682;

  localparam logic [6:0] GRID_DIM_RESET = 7'd64;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               blocked;
    logic               in_grid;
  } entry_t;

  typedef struct packed {
    logic [15:0]        lim_w;
    logic [15:0]        lim_h;
    logic               eight_way;
    logic               allow_corner;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
  } cfg_t;

  typedef struct packed {
    logic        report_kind;
    logic [15:0] cell_index;
    logic        out_of_bounds;
    logic        on_obstacle;
    logic        not_adjacent;
    logic        corner_cut;
    logic        empty_path;
    logic        start_mismatch;
    logic        goal_mismatch;
    logic [15:0] path_length;
    logic [31:0] path_cost;
    logic        path_valid;
  } res_t;

  function automatic logic in_lim(input logic signed [15:0] v, input logic [15:0] lim);
    return !v[15] && ($unsigned(v) < lim);
  endfunction

endpackage

### rtl/gpv_chan_if.sv
// ----------------------------------------------------------------------------
// Grid path validator channels
// Valid/ready request and result channels with their payload fields.
// ----------------------------------------------------------------------------
interface gpv_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] cell_x;
  logic signed [15:0] cell_y;
  logic               blocked;

  modport source (output valid, output req_type, output cell_x, output cell_y,
                  output blocked, input ready);
  modport sink (input valid, input req_type, input cell_x, input cell_y,
                input blocked, output ready);
endinterface

interface gpv_res_if;
  logic        valid;
  logic        ready;
  logic        report_kind;
  logic [15:0] cell_index;
  logic        out_of_bounds;
  logic        on_obstacle;
  logic        not_adjacent;
  logic        corner_cut;
  logic        empty_path;
  logic        start_mismatch;
  logic        goal_mismatch;
  logic [15:0] path_length;
  logic [31:0] path_cost;
  logic        path_valid;

  modport source (output valid, output report_kind, output cell_index,
                  output out_of_bounds, output on_obstacle, output not_adjacent,
                  output corner_cut, output empty_path, output start_mismatch,
                  output goal_mismatch, output path_length, output path_cost,
                  output path_valid, input ready);
  modport sink (input valid, input report_kind, input cell_index,
                input out_of_bounds, input on_obstacle, input not_adjacent,
                input corner_cut, input empty_path, input start_mismatch,
                input goal_mismatch, input path_length, input path_cost,
                input path_valid, output ready);
endinterface

### rtl/gpv_front.sv
// ----------------------------------------------------------------------------
// Grid path validator front end
// Accept requests, drop REQ_NONE codes, tag cells with their grid bounds check.
// ----------------------------------------------------------------------------
module gpv_front (
  gpv_req_if.sink        in_chan,
  input  gpv_pkg::cfg_t  cfg,
  input  logic           q_full,
  output logic           q_push,
  output gpv_pkg::entry_t q_entry
);

  assign in_chan.ready = !q_full;
  assign q_push = in_chan.valid && !q_full && (in_chan.req_type != gpv_pkg::REQ_NONE);

  always_comb begin
    q_entry.kind    = in_chan.req_type;
    q_entry.x       = in_chan.cell_x;
    q_entry.y       = in_chan.cell_y;
    q_entry.blocked = in_chan.blocked;
    q_entry.in_grid = gpv_pkg::in_lim(in_chan.cell_x, cfg.lim_w) &&
                      gpv_pkg::in_lim(in_chan.cell_y, cfg.lim_h);
  end

endmodule

### rtl/gpv_queue.sv
// ----------------------------------------------------------------------------
// Grid path validator request queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module gpv_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gpv_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output gpv_pkg::entry_t head
);

  localparam int PW = $clog2(gpv_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(gpv_pkg::QUEUE_DEPTH + 1);

  gpv_pkg::entry_t slot_r [gpv_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign full       = (count_r == CW'(gpv_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(gpv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(gpv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/gpv_back.sv
// ----------------------------------------------------------------------------
// Grid path validator back end
// Sequence map accesses, evaluate path steps, keep path totals, drive results.
// ----------------------------------------------------------------------------
module gpv_back #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gpv_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  gpv_pkg::entry_t q_entry,
  output logic            q_pop,
  input  logic            out_ready,
  output logic            out_valid,
  output gpv_pkg::res_t   out_res
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] PH_TAKE   = 2'd0;
  localparam logic [1:0] PH_SIDE_A = 2'd1;
  localparam logic [1:0] PH_SIDE_B = 2'd2;

  function automatic logic [AW-1:0] map_addr(input logic [15:0] cx, input logic [15:0] cy);
    return AW'(AW'(cy[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(cx[XW-1:0]);
  endfunction

  logic              map_mem [DEPTH];
  logic              rd_r;

  logic [1:0]        phase_r;
  gpv_pkg::entry_t   cur_r;
  logic              fin_v_r;
  logic              cell_blk_r, side_a_blk_r, straight_r, diag_r;
  logic signed [15:0] prev_x_r, prev_y_r;
  logic [15:0]       cnt_r;
  logic [31:0]       cost_r;
  logic              first_diff_r, any_err_r;
  logic              out_v_r;
  gpv_pkg::res_t     res_r;

  logic              out_free, advance, fin_done, fin_load;
  logic              mem_we, mem_re;
  logic [AW-1:0]     addr;
  logic              side_a_in, side_b_in, side_b_blk;
  logic [16:0]       dx, dy, adx, ady;
  logic              straight_c, diag_c;
  logic              first, diag_ok, oob, obs, nadj, cut, gm;
  logic [31:0]       add;
  logic [32:0]       sum;
  logic [31:0]       cost_sat;
  gpv_pkg::res_t     res_c;

  assign out_free = !out_v_r || out_ready;
  assign advance  = !fin_v_r || out_free;
  assign fin_done = fin_v_r && advance;

  assign q_pop = advance && (phase_r == PH_TAKE) && q_valid;

  assign side_a_in = gpv_pkg::in_lim(prev_x_r, cfg.lim_w) && gpv_pkg::in_lim(cur_r.y, cfg.lim_h);
  assign side_b_in = gpv_pkg::in_lim(cur_r.x, cfg.lim_w) && gpv_pkg::in_lim(prev_y_r, cfg.lim_h);

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    addr   = map_addr(q_entry.x, q_entry.y);
    unique case (phase_r)
      PH_TAKE: begin
        mem_we = q_pop && (q_entry.kind == gpv_pkg::REQ_WRITE) && q_entry.in_grid;
        mem_re = q_pop && (q_entry.kind == gpv_pkg::REQ_CELL) && q_entry.in_grid;
      end
      PH_SIDE_A: begin
        addr   = map_addr(prev_x_r, cur_r.y);
        mem_re = advance && side_a_in;
      end
      PH_SIDE_B: begin
        addr   = map_addr(cur_r.x, prev_y_r);
        mem_re = advance && side_b_in;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[addr] <= q_entry.blocked;
    end
    if (mem_re) begin
      rd_r <= map_mem[addr];
    end
  end

  always_comb begin
    dx  = {prev_x_r[15], prev_x_r} - {cur_r.x[15], cur_r.x};
    dy  = {prev_y_r[15], prev_y_r} - {cur_r.y[15], cur_r.y};
    adx = dx[16] ? 17'(-dx) : dx;
    ady = dy[16] ? 17'(-dy) : dy;
    straight_c = ((adx == 17'd1) && (ady == 17'd0)) || ((adx == 17'd0) && (ady == 17'd1));
    diag_c     = (adx == 17'd1) && (ady == 17'd1);
  end

  always_comb begin
    first      = (cnt_r == 16'd0);
    diag_ok    = diag_r && cfg.eight_way;
    side_b_blk = !side_b_in || rd_r;
    oob        = !cur_r.in_grid;
    obs        = cur_r.in_grid && cell_blk_r;
    nadj       = !first && !straight_r && !diag_ok;
    cut        = !first && diag_ok && !cfg.allow_corner && (side_a_blk_r || side_b_blk);
    if (first) begin
      add = 32'd0;
    end else if (straight_r) begin
      add = gpv_pkg::COST_STRAIGHT;
    end else if (diag_ok) begin
      add = gpv_pkg::COST_DIAGONAL;
    end else begin
      add = 32'd0;
    end
    sum      = {1'b0, cost_r} + {1'b0, add};
    cost_sat = sum[32] ? '1 : sum[31:0];
    gm       = (prev_x_r != cfg.goal_x) || (prev_y_r != cfg.goal_y);

    res_c = '0;
    if (cur_r.kind == gpv_pkg::REQ_CELL) begin
      res_c.cell_index    = cnt_r;
      res_c.out_of_bounds = oob;
      res_c.on_obstacle   = obs;
      res_c.not_adjacent  = nadj;
      res_c.corner_cut    = cut;
    end else begin
      res_c.report_kind = 1'b1;
      if (first) begin
        res_c.empty_path = 1'b1;
      end else begin
        res_c.start_mismatch = first_diff_r;
        res_c.goal_mismatch  = gm;
        res_c.path_length    = cnt_r;
        res_c.path_cost      = cost_r;
        res_c.path_valid     = !(any_err_r || first_diff_r || gm);
      end
    end
  end

  assign fin_load = (phase_r == PH_SIDE_B) ||
                    (q_pop && (q_entry.kind == gpv_pkg::REQ_FINISH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TAKE;
      fin_v_r      <= 1'b0;
      out_v_r      <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      cnt_r        <= '0;
      cost_r       <= '0;
      first_diff_r <= 1'b0;
      any_err_r    <= 1'b0;
    end else begin
      if (advance) begin
        fin_v_r <= fin_load;
        unique case (phase_r)
          PH_TAKE: begin
            if (q_pop && (q_entry.kind == gpv_pkg::REQ_CELL)) begin
              phase_r <= PH_SIDE_A;
            end
          end
          PH_SIDE_A: phase_r <= PH_SIDE_B;
          PH_SIDE_B: phase_r <= PH_TAKE;
          default:   phase_r <= PH_TAKE;
        endcase
      end

      if (fin_done) begin
        out_v_r <= 1'b1;
        if (cur_r.kind == gpv_pkg::REQ_CELL) begin
          if (cnt_r != '1) begin
            cnt_r <= cnt_r + 16'd1;
          end
          cost_r   <= cost_sat;
          prev_x_r <= cur_r.x;
          prev_y_r <= cur_r.y;
          if (first) begin
            first_diff_r <= (cur_r.x != cfg.start_x) || (cur_r.y != cfg.start_y);
          end
          if (oob || obs || nadj || cut) begin
            any_err_r <= 1'b1;
          end
        end else begin
          prev_x_r     <= '0;
          prev_y_r     <= '0;
          cnt_r        <= '0;
          cost_r       <= '0;
          first_diff_r <= 1'b0;
          any_err_r    <= 1'b0;
        end
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_entry;
    end
    if (advance && (phase_r == PH_SIDE_A)) begin
      cell_blk_r <= rd_r;
      straight_r <= straight_c;
      diag_r     <= diag_c;
    end
    if (advance && (phase_r == PH_SIDE_B)) begin
      side_a_blk_r <= !side_a_in || rd_r;
    end
    if (fin_done) begin
      res_r <= res_c;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = res_r;

endmodule

### rtl/grid_path_validator.sv
// ----------------------------------------------------------------------------
// Grid path validator
// Checks a planned path against an occupancy grid, one report per path cell
// and one summary per finished path.
// ----------------------------------------------------------------------------
//  channel   direction  protocol     payload
//  in_chan   in         valid/ready  req_type, cell_x, cell_y, blocked
//  out_chan  out        valid/ready  per-cell report or path summary
//  cfg_*     in         write only   cfg_idx selects one of eight registers
//
//  A path cell makes three reads (cell, two side cells) of the single-port
//  occupancy map, one per back-end phase: take, side A, side B. A grid write
//  or a finish request uses the take phase only. Results pass a finish stage,
//  then the output register. Reset is synchronous; the map holds no reset
//  value, so a cell reads unknown until written. A stalled result holds the
//  back end; the front keeps taking requests until the two-entry queue fills.
// ----------------------------------------------------------------------------
module grid_path_validator #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  gpv_req_if.sink     in_chan,
  gpv_res_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  logic [6:0]         grid_width_r, grid_height_r;
  logic               eight_way_r, allow_corner_r;
  logic signed [15:0] start_x_r, start_y_r, goal_x_r, goal_y_r;

  gpv_pkg::cfg_t      cfg;
  gpv_pkg::entry_t    push_entry, head;
  gpv_pkg::res_t      res;
  logic               q_push, q_pop, q_full, q_valid, res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r   <= gpv_pkg::GRID_DIM_RESET;
      grid_height_r  <= gpv_pkg::GRID_DIM_RESET;
      eight_way_r    <= 1'b0;
      allow_corner_r <= 1'b0;
      start_x_r      <= '0;
      start_y_r      <= '0;
      goal_x_r       <= '0;
      goal_y_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        gpv_pkg::CFG_GRID_WIDTH:   grid_width_r   <= cfg_wdata[6:0];
        gpv_pkg::CFG_GRID_HEIGHT:  grid_height_r  <= cfg_wdata[6:0];
        gpv_pkg::CFG_EIGHT_WAY:    eight_way_r    <= cfg_wdata[0];
        gpv_pkg::CFG_ALLOW_CORNER: allow_corner_r <= cfg_wdata[0];
        gpv_pkg::CFG_START_X:      start_x_r      <= cfg_wdata;
        gpv_pkg::CFG_START_Y:      start_y_r      <= cfg_wdata;
        gpv_pkg::CFG_GOAL_X:       goal_x_r       <= cfg_wdata;
        gpv_pkg::CFG_GOAL_Y:       goal_y_r       <= cfg_wdata;
        default:                   start_x_r      <= start_x_r;
      endcase
    end
  end

  always_comb begin
    cfg.lim_w = ({9'd0, grid_width_r} < 16'(MAX_WIDTH)) ? {9'd0, grid_width_r}
                                                        : 16'(MAX_WIDTH);
    cfg.lim_h = ({9'd0, grid_height_r} < 16'(MAX_HEIGHT)) ? {9'd0, grid_height_r}
                                                          : 16'(MAX_HEIGHT);
    cfg.eight_way    = eight_way_r;
    cfg.allow_corner = allow_corner_r;
    cfg.start_x      = start_x_r;
    cfg.start_y      = start_y_r;
    cfg.goal_x       = goal_x_r;
    cfg.goal_y       = goal_y_r;
  end

  gpv_front u_front (
    .in_chan (in_chan),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  gpv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head       (head)
  );

  gpv_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (head),
    .q_pop     (q_pop),
    .out_ready (out_chan.ready),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign out_chan.valid          = res_valid;
  assign out_chan.report_kind    = res.report_kind;
  assign out_chan.cell_index     = res.cell_index;
  assign out_chan.out_of_bounds  = res.out_of_bounds;
  assign out_chan.on_obstacle    = res.on_obstacle;
  assign out_chan.not_adjacent   = res.not_adjacent;
  assign out_chan.corner_cut     = res.corner_cut;
  assign out_chan.empty_path     = res.empty_path;
  assign out_chan.start_mismatch = res.start_mismatch;
  assign out_chan.goal_mismatch  = res.goal_mismatch;
  assign out_chan.path_length    = res.path_length;
  assign out_chan.path_cost      = res.path_cost;
  assign out_chan.path_valid     = res.path_valid;

endmodule

### rtl/gpv_checker.sv
// ----------------------------------------------------------------------------
// Grid path validator checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_path_validator_macros.svh"

module gpv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        report_kind,
  input logic [15:0] cell_index,
  input logic        out_of_bounds,
  input logic        on_obstacle,
  input logic        empty_path,
  input logic [15:0] path_length,
  input logic [31:0] path_cost,
  input logic        path_valid
);

  `GPV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `GPV_ASSERT_NOW(a_cell_clean, out_valid && !report_kind, !empty_path && (path_length == 16'd0) && (path_cost == 32'd0) && !path_valid, "cell report carries summary fields")
  `GPV_ASSERT_NOW(a_sum_clean, out_valid && report_kind, (cell_index == 16'd0) && !out_of_bounds && !on_obstacle, "summary carries cell fields")
  `GPV_ASSERT_NOW(a_empty, out_valid && empty_path, !path_valid && (path_length == 16'd0) && (path_cost == 32'd0), "empty path summary not clean")

endmodule

bind grid_path_validator gpv_checker u_gpv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .report_kind   (out_chan.report_kind),
  .cell_index    (out_chan.cell_index),
  .out_of_bounds (out_chan.out_of_bounds),
  .on_obstacle   (out_chan.on_obstacle),
  .empty_path    (out_chan.empty_path),
  .path_length   (out_chan.path_length),
  .path_cost     (out_chan.path_cost),
  .path_valid    (out_chan.path_valid)
);

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Grid path validator testbench
// Loads a corner of the occupancy map, then runs short checks of the corner
// cases, a back-and-forth diagonal path, and random phases of routes, grid
// writes and junk requests under new settings. Map cells that a path step reads
// are written before the step is sent. Every result is compared field by field
// against a path checker kept inside the bench, with random sender bursts on
// the request channel and receiver stalls on the result channel.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAP_COLS      = 64;
  localparam int MAP_ROWS      = 64;
  localparam int FILL_SPAN     = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int LONG_CELLS    = 64;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  gpv_req_if req_bus();
  gpv_res_if res_bus();

  grid_path_validator #(
    .MAX_WIDTH(MAP_COLS),
    .MAX_HEIGHT(MAP_ROWS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(req_bus),
    .out_chan(res_bus),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  bit          occ_map [0:MAP_COLS*MAP_ROWS-1];
  bit          occ_set [0:MAP_COLS*MAP_ROWS-1];
  logic [6:0]  cfg_w = gpv_pkg::GRID_DIM_RESET;
  logic [6:0]  cfg_h = gpv_pkg::GRID_DIM_RESET;
  logic        cfg_diag = 1'b0;
  logic        cfg_corner = 1'b0;
  logic [15:0] cfg_sx = '0;
  logic [15:0] cfg_sy = '0;
  logic [15:0] cfg_gx = '0;
  logic [15:0] cfg_gy = '0;
  logic [15:0] last_x = '0;
  logic [15:0] last_y = '0;
  logic [15:0] run_len = '0;
  logic [31:0] run_cost = '0;
  logic        first_off = 1'b0;
  logic        run_err = 1'b0;

  gpv_pkg::res_t due_reports[$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;
  int   rx_stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #150_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic bit cell_in_grid(input int x, input int y);
    int w;
    int h;
    w = (cfg_w < MAP_COLS) ? int'(cfg_w) : MAP_COLS;
    h = (cfg_h < MAP_ROWS) ? int'(cfg_h) : MAP_ROWS;
    return x >= 0 && y >= 0 && x < w && y < h;
  endfunction

  function automatic bit cell_blocked_at(input int x, input int y);
    if (!cell_in_grid(x, y)) return 1'b1;
    return occ_map[y*MAP_COLS + x];
  endfunction

  task automatic grade_request(input logic [1:0] kind, input logic [15:0] rx,
                               input logic [15:0] ry, input logic blk);
    int            x;
    int            y;
    int            px;
    int            py;
    int            dx;
    int            dy;
    logic [31:0]   step_cost;
    logic          goal_off;
    gpv_pkg::res_t r;
    x = $signed(rx);
    y = $signed(ry);
    r = '0;
    case (kind)
      gpv_pkg::REQ_WRITE: begin
        if (cell_in_grid(x, y)) begin
          occ_map[y*MAP_COLS + x] = blk;
          occ_set[y*MAP_COLS + x] = 1'b1;
        end
      end
      gpv_pkg::REQ_CELL: begin
        r.out_of_bounds = !cell_in_grid(x, y);
        r.on_obstacle = !r.out_of_bounds && occ_map[y*MAP_COLS + x];
        if (run_len == 0) begin
          first_off = (rx != cfg_sx) || (ry != cfg_sy);
        end else begin
          px = $signed(last_x);
          py = $signed(last_y);
          dx = (px > x) ? px - x : x - px;
          dy = (py > y) ? py - y : y - py;
          step_cost = '0;
          if (dx + dy == 1) begin
            step_cost = gpv_pkg::COST_STRAIGHT;
          end else if (dx == 1 && dy == 1 && cfg_diag) begin
            step_cost = gpv_pkg::COST_DIAGONAL;
            r.corner_cut = !cfg_corner && (cell_blocked_at(px, y) || cell_blocked_at(x, py));
          end else begin
            r.not_adjacent = 1'b1;
          end
          run_cost = (run_cost > 32'hFFFF_FFFF - step_cost) ? 32'hFFFF_FFFF
                                                             : run_cost + step_cost;
        end
        if (r.out_of_bounds || r.on_obstacle || r.not_adjacent || r.corner_cut) run_err = 1'b1;
        r.report_kind = 1'b0;
        r.cell_index = run_len;
        if (run_len != 16'hFFFF) run_len = run_len + 16'd1;
        last_x = rx;
        last_y = ry;
        due_reports = {due_reports, r};
      end
      gpv_pkg::REQ_FINISH: begin
        r.report_kind = 1'b1;
        if (run_len == 0) begin
          r.empty_path = 1'b1;
        end else begin
          goal_off = (last_x != cfg_gx) || (last_y != cfg_gy);
          r.start_mismatch = first_off;
          r.goal_mismatch = goal_off;
          r.path_length = run_len;
          r.path_cost = run_cost;
          r.path_valid = !(run_err || first_off || goal_off);
        end
        due_reports = {due_reports, r};
        last_x = '0;
        last_y = '0;
        run_len = '0;
        run_cost = '0;
        first_off = 1'b0;
        run_err = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic put_req(input logic [1:0] kind, input int x, input int y, input logic blk);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        req_bus.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_bus.req_type = kind;
    req_bus.cell_x = 16'(x);
    req_bus.cell_y = 16'(y);
    req_bus.blocked = blk;
    req_bus.valid = 1'b1;
    do @(posedge clk); while (!req_bus.ready);
    grade_request(kind, 16'(x), 16'(y), blk);
    if (kind != gpv_pkg::REQ_NONE) items_sent++;
  endtask

  task automatic prime_cell(input int x, input int y);
    if (cell_in_grid(x, y) && !occ_set[y*MAP_COLS + x])
      put_req(gpv_pkg::REQ_WRITE, x, y, $urandom_range(0, 3) == 0);
  endtask

  task automatic send_req(input logic [1:0] kind, input int x, input int y, input logic blk);
    int cx;
    int cy;
    int px;
    int py;
    cx = int'($signed(16'(x)));
    cy = int'($signed(16'(y)));
    if (kind == gpv_pkg::REQ_CELL) begin
      prime_cell(cx, cy);
      if (run_len != 16'd0 && cfg_diag && !cfg_corner) begin
        px = int'($signed(last_x));
        py = int'($signed(last_y));
        if ((px - cx == 1 || cx - px == 1) && (py - cy == 1 || cy - py == 1)) begin
          prime_cell(px, cy);
          prime_cell(cx, py);
        end
      end
    end
    put_req(kind, x, y, blk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(posedge clk);
    case (idx)
      gpv_pkg::CFG_GRID_WIDTH:   cfg_w = value[6:0];
      gpv_pkg::CFG_GRID_HEIGHT:  cfg_h = value[6:0];
      gpv_pkg::CFG_EIGHT_WAY:    cfg_diag = value[0];
      gpv_pkg::CFG_ALLOW_CORNER: cfg_corner = value[0];
      gpv_pkg::CFG_START_X:      cfg_sx = value;
      gpv_pkg::CFG_START_Y:      cfg_sy = value;
      gpv_pkg::CFG_GOAL_X:       cfg_gx = value;
      gpv_pkg::CFG_GOAL_Y:       cfg_gy = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    req_bus.valid = 1'b0;
    burst_left = 0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_path_mode(input logic diag, input logic corner, input int sx,
                               input int sy, input int gx, input int gy);
    drain_and_settle();
    write_reg(gpv_pkg::CFG_EIGHT_WAY, {15'd0, diag});
    write_reg(gpv_pkg::CFG_ALLOW_CORNER, {15'd0, corner});
    write_reg(gpv_pkg::CFG_START_X, 16'(sx));
    write_reg(gpv_pkg::CFG_START_Y, 16'(sy));
    write_reg(gpv_pkg::CFG_GOAL_X, 16'(gx));
    write_reg(gpv_pkg::CFG_GOAL_Y, 16'(gy));
  endtask

  task automatic report_fault(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  function automatic string show_result(input gpv_pkg::res_t r);
    return $sformatf({"kind=%0d idx=%0d oob=%0d obs=%0d nadj=%0d cut=%0d empty=%0d ",
                      "smis=%0d gmis=%0d len=%0d cost=%h valid=%0d"},
                     r.report_kind, r.cell_index, r.out_of_bounds, r.on_obstacle,
                     r.not_adjacent, r.corner_cut, r.empty_path, r.start_mismatch,
                     r.goal_mismatch, r.path_length, r.path_cost, r.path_valid);
  endfunction

  always @(posedge clk) begin : check_results
    gpv_pkg::res_t got;
    gpv_pkg::res_t want;
    string         diff;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got.report_kind = res_bus.report_kind;
      got.cell_index = res_bus.cell_index;
      got.out_of_bounds = res_bus.out_of_bounds;
      got.on_obstacle = res_bus.on_obstacle;
      got.not_adjacent = res_bus.not_adjacent;
      got.corner_cut = res_bus.corner_cut;
      got.empty_path = res_bus.empty_path;
      got.start_mismatch = res_bus.start_mismatch;
      got.goal_mismatch = res_bus.goal_mismatch;
      got.path_length = res_bus.path_length;
      got.path_cost = res_bus.path_cost;
      got.path_valid = res_bus.path_valid;
      if (due_reports.size() == 0) begin
        report_fault({"unexpected result: ", show_result(got)});
      end else begin
        want = due_reports.pop_front();
        diff = "";
        if (got.report_kind !== want.report_kind) diff = {diff, " report_kind"};
        if (got.cell_index !== want.cell_index) diff = {diff, " cell_index"};
        if (got.out_of_bounds !== want.out_of_bounds) diff = {diff, " out_of_bounds"};
        if (got.on_obstacle !== want.on_obstacle) diff = {diff, " on_obstacle"};
        if (got.not_adjacent !== want.not_adjacent) diff = {diff, " not_adjacent"};
        if (got.corner_cut !== want.corner_cut) diff = {diff, " corner_cut"};
        if (got.empty_path !== want.empty_path) diff = {diff, " empty_path"};
        if (got.start_mismatch !== want.start_mismatch) diff = {diff, " start_mismatch"};
        if (got.goal_mismatch !== want.goal_mismatch) diff = {diff, " goal_mismatch"};
        if (got.path_length !== want.path_length) diff = {diff, " path_length"};
        if (got.path_cost !== want.path_cost) diff = {diff, " path_cost"};
        if (got.path_valid !== want.path_valid) diff = {diff, " path_valid"};
        if (diff != "")
          report_fault({"mismatch in", diff, "\n  expected ", show_result(want),
                        "\n  actual   ", show_result(got)});
      end
    end
  end

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      0: res_bus.ready = 1'b1;
      1: res_bus.ready = $urandom_range(0, 1);
      2: res_bus.ready = ($urandom_range(0, 4) == 0);
      default: begin
        if (rx_stall_left > 0) begin
          res_bus.ready = 1'b0;
          rx_stall_left--;
        end else begin
          res_bus.ready = 1'b1;
          rx_stall_left = $urandom_range(5, 30);
        end
      end
    endcase
  end

  task automatic test_grid_fill();
    for (int y = 0; y < FILL_SPAN; y++)
      for (int x = 0; x < FILL_SPAN; x++)
        send_req(gpv_pkg::REQ_WRITE, x, y, $urandom_range(0, 3) == 0);
  endtask

  task automatic test_four_way();
    set_path_mode(1'b0, 1'b0, 0, 0, 2, 0);
    send_req(gpv_pkg::REQ_FINISH, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_WRITE, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_WRITE, 1, 0, 1'b0);
    send_req(gpv_pkg::REQ_WRITE, 2, 0, 1'b0);
    send_req(gpv_pkg::REQ_WRITE, -1, 3, 1'b1);
    send_req(gpv_pkg::REQ_WRITE, 64, 0, 1'b1);
    send_req(gpv_pkg::REQ_NONE, -1, -1, 1'b1);
    send_req(gpv_pkg::REQ_CELL, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_CELL, 1, 0, 1'b0);
    send_req(gpv_pkg::REQ_CELL, 2, 0, 1'b0);
    send_req(gpv_pkg::REQ_FINISH, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_WRITE, 63, 63, 1'b1);
    send_req(gpv_pkg::REQ_CELL, 1, 1, 1'b1);
    send_req(gpv_pkg::REQ_CELL, 2, 2, 1'b0);
    send_req(gpv_pkg::REQ_CELL, 32767, -32768, 1'b0);
    send_req(gpv_pkg::REQ_CELL, -32768, 32767, 1'b1);
    send_req(gpv_pkg::REQ_CELL, 63, 63, 1'b0);
    send_req(gpv_pkg::REQ_FINISH, -1, -1, 1'b1);
  endtask

  task automatic test_diagonal_steps();
    set_path_mode(1'b1, 1'b0, 0, 0, 1, 1);
    send_req(gpv_pkg::REQ_WRITE, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_WRITE, 1, 1, 1'b0);
    send_req(gpv_pkg::REQ_WRITE, 1, 0, 1'b1);
    send_req(gpv_pkg::REQ_CELL, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_CELL, 1, 1, 1'b0);
    send_req(gpv_pkg::REQ_CELL, 0, 2, 1'b0);
    send_req(gpv_pkg::REQ_CELL, -1, 3, 1'b0);
    send_req(gpv_pkg::REQ_FINISH, 0, 0, 1'b0);
    set_path_mode(1'b1, 1'b1, 0, 0, 1, 1);
    send_req(gpv_pkg::REQ_CELL, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_CELL, 1, 1, 1'b0);
    send_req(gpv_pkg::REQ_FINISH, 0, 0, 1'b0);
  endtask

  task automatic test_grid_limits();
    drain_and_settle();
    write_reg(gpv_pkg::CFG_GRID_WIDTH, 16'd1);
    write_reg(gpv_pkg::CFG_GRID_HEIGHT, 16'd1);
    send_req(gpv_pkg::REQ_CELL, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_CELL, 1, 0, 1'b0);
    send_req(gpv_pkg::REQ_FINISH, 0, 0, 1'b0);
    drain_and_settle();
    write_reg(gpv_pkg::CFG_GRID_WIDTH, 16'd0);
    write_reg(gpv_pkg::CFG_GRID_HEIGHT, 16'd127);
    send_req(gpv_pkg::REQ_CELL, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_FINISH, 0, 0, 1'b0);
    drain_and_settle();
    write_reg(gpv_pkg::CFG_GRID_WIDTH, 16'd127);
    write_reg(gpv_pkg::CFG_GRID_HEIGHT, 16'd64);
  endtask

  task automatic test_long_path();
    set_path_mode(1'b1, 1'b1, 0, 0, 1, 1);
    send_req(gpv_pkg::REQ_WRITE, 0, 0, 1'b0);
    send_req(gpv_pkg::REQ_WRITE, 1, 1, 1'b0);
    for (int i = 0; i < LONG_CELLS; i++)
      send_req(gpv_pkg::REQ_CELL, i % 2, i % 2, 1'b0);
    send_req(gpv_pkg::REQ_FINISH, 0, 0, 1'b0);
  endtask

  function automatic logic [6:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd64;
      4: return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(3, 64));
    endcase
  endfunction

  function automatic int near_border(input int lim);
    case ($urandom_range(0, 6))
      0: return -1;
      1: return 0;
      2: return lim - 1;
      3: return lim;
      4: return 32767;
      5: return -32768;
      default: return int'($urandom);
    endcase
  endfunction

  task automatic configure_phase();
    logic [6:0] w;
    logic [6:0] h;
    int         w_use;
    int         h_use;
    int         sx;
    int         sy;
    int         gx;
    int         gy;
    int         off;
    bit         garble;
    w = pick_dim();
    h = pick_dim();
    garble = ($urandom_range(0, 7) == 0);
    drain_and_settle();
    write_reg(gpv_pkg::CFG_GRID_WIDTH, {garble ? 9'($urandom) : 9'd0, w});
    write_reg(gpv_pkg::CFG_GRID_HEIGHT, {garble ? 9'($urandom) : 9'd0, h});
    write_reg(gpv_pkg::CFG_EIGHT_WAY,
              {garble ? 15'($urandom) : 15'd0, 1'($urandom_range(0, 1))});
    write_reg(gpv_pkg::CFG_ALLOW_CORNER,
              {garble ? 15'($urandom) : 15'd0, 1'($urandom_range(0, 3) == 0)});
    w_use = (w < MAP_COLS) ? int'(w) : MAP_COLS;
    h_use = (h < MAP_ROWS) ? int'(h) : MAP_ROWS;
    if (w_use > 0 && h_use > 0 && $urandom_range(0, 9) != 0) begin
      sx = $urandom_range(0, w_use - 1);
      sy = $urandom_range(0, h_use - 1);
    end else begin
      sx = near_border(w_use);
      sy = near_border(h_use);
    end
    case ($urandom_range(0, 9))
      0: begin
        gx = sx;
        gy = sy;
      end
      1: begin
        gx = int'($urandom);
        gy = int'($urandom);
      end
      default: begin
        off = $urandom_range(0, 14);
        gx = sx + off - 7;
        off = $urandom_range(0, 14);
        gy = sy + off - 7;
      end
    endcase
    write_reg(gpv_pkg::CFG_START_X, 16'(sx));
    write_reg(gpv_pkg::CFG_START_Y, 16'(sy));
    write_reg(gpv_pkg::CFG_GOAL_X, 16'(gx));
    write_reg(gpv_pkg::CFG_GOAL_Y, 16'(gy));
  endtask

  task automatic run_route();
    int cx;
    int cy;
    int tx;
    int ty;
    int mx;
    int my;
    int k;
    int pick;
    int route_x[$];
    int route_y[$];
    cx = int'($signed(cfg_sx));
    cy = int'($signed(cfg_sy));
    tx = int'($signed(cfg_gx));
    ty = int'($signed(cfg_gy));
    route_x = {route_x, cx};
    route_y = {route_y, cy};
    while ((cx != tx || cy != ty) && route_x.size() < 25) begin
      mx = (tx > cx) - (tx < cx);
      my = (ty > cy) - (ty < cy);
      if ($urandom_range(0, 6) == 0) begin
        mx = $urandom_range(0, 1) ? 1 : -1;
        my = $urandom_range(0, 1) ? 1 : -1;
        if ($urandom_range(0, 1)) mx = 0;
        else if (!cfg_diag || $urandom_range(0, 1)) my = 0;
      end else if (mx != 0 && my != 0 && !(cfg_diag && $urandom_range(0, 2) != 0)) begin
        if ($urandom_range(0, 1)) mx = 0;
        else my = 0;
      end
      cx += mx;
      cy += my;
      route_x = {route_x, cx};
      route_y = {route_y, cy};
    end
    if ($urandom_range(0, 9) < 7) begin
      foreach (route_x[i]) begin
        send_req(gpv_pkg::REQ_WRITE, route_x[i], route_y[i], 1'b0);
        if (i > 0 && route_x[i] != route_x[i-1] && route_y[i] != route_y[i-1]) begin
          if ($urandom_range(0, 4) != 0)
            send_req(gpv_pkg::REQ_WRITE, route_x[i-1], route_y[i], 1'b0);
          if ($urandom_range(0, 4) != 0)
            send_req(gpv_pkg::REQ_WRITE, route_x[i], route_y[i-1], 1'b0);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, route_x.size() - 1);
        send_req(gpv_pkg::REQ_WRITE, route_x[k] + $urandom_range(0, 1), route_y[k], 1'b1);
      end
    end
    foreach (route_x[i]) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) continue;
      if (pick < 6)
        send_req(gpv_pkg::REQ_CELL, int'($urandom), int'($urandom), $urandom_range(0, 1));
      else
        send_req(gpv_pkg::REQ_CELL, route_x[i], route_y[i], $urandom_range(0, 1));
    end
    if ($urandom_range(0, 11) != 0)
      send_req(gpv_pkg::REQ_FINISH, int'($urandom), int'($urandom), $urandom_range(0, 1));
  endtask

  task automatic test_random_traffic();
    int w_use;
    int h_use;
    int start_count;
    int phase_start;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      configure_phase();
      w_use = (cfg_w < MAP_COLS) ? int'(cfg_w) : MAP_COLS;
      h_use = (cfg_h < MAP_ROWS) ? int'(cfg_h) : MAP_ROWS;
      phase_start = items_sent;
      while (items_sent - phase_start < 50) begin
        case ($urandom_range(0, 99)) inside
          [0:64]: run_route();
          [65:74]: begin
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(0, 1) && w_use > 0 && h_use > 0)
                send_req(gpv_pkg::REQ_WRITE, $urandom_range(0, w_use - 1),
                         $urandom_range(0, h_use - 1), $urandom_range(0, 1));
              else
                send_req(gpv_pkg::REQ_WRITE, int'($urandom), int'($urandom),
                         $urandom_range(0, 1));
            end
          end
          [75:81]: send_req(gpv_pkg::REQ_NONE, int'($urandom), int'($urandom),
                            $urandom_range(0, 1));
          [82:87]: send_req(gpv_pkg::REQ_FINISH, int'($urandom), int'($urandom),
                            $urandom_range(0, 1));
          default: begin
            repeat ($urandom_range(1, 5))
              send_req(gpv_pkg::REQ_CELL, near_border(w_use), near_border(h_use),
                       $urandom_range(0, 1));
            send_req(gpv_pkg::REQ_FINISH, int'($urandom), int'($urandom),
                     $urandom_range(0, 1));
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = gpv_pkg::CFG_GRID_WIDTH;
    cfg_wdata = '0;
    req_bus.valid = 1'b0;
    req_bus.req_type = gpv_pkg::REQ_WRITE;
    req_bus.cell_x = '0;
    req_bus.cell_y = '0;
    req_bus.blocked = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_grid_fill();
    test_four_way();
    test_diagonal_steps();
    test_grid_limits();
    test_long_path();
    test_random_traffic();
    drain_and_settle();
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
